// ----- hdl/tbc_pkg.sv -----
package tbc_pkg;

   // Command passed from the front to the back through the queue
   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_PIXELS = 2'd1,
      CMD_DONE   = 2'd2
   } cmd_kind_type;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   // Four mirrors per neighbor, seven neighbors per thick pixel
   localparam logic [1:0] MIRROR_LAST   = 2'd3;
   localparam logic [2:0] NEIGHBOR_LAST = 3'd6;

   // Neighbor offsets: (0,0) (+1,0) (0,+1) (+1,+1) (-1,0) (0,-1) (-1,-1)
   function automatic logic [1:0] nb_dx(input logic [2:0] n);
      logic [1:0] d;
      case (n)
         3'd1, 3'd3: d = 2'b01;
         3'd4, 3'd6: d = 2'b11;
         default:    d = 2'b00;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] nb_dy(input logic [2:0] n);
      logic [1:0] d;
      case (n)
         3'd2, 3'd3: d = 2'b01;
         3'd5, 3'd6: d = 2'b11;
         default:    d = 2'b00;
      endcase
      return d;
   endfunction

endpackage

// ----- hdl/tbc_front.sv -----
module tbc_front #(
   parameter int COORD_WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [COORD_WIDTH-1:0]   req_center_x,
   input  logic [COORD_WIDTH-1:0]   req_center_y,
   input  logic [COORD_WIDTH-1:0]   req_radius,
   input  logic [3:0]               req_pen_color,
   output logic                     cmd_valid,
   input  logic                     cmd_stall,
   output tbc_pkg::cmd_kind_type    cmd_kind,
   output logic [COORD_WIDTH-1:0]   cmd_cx,
   output logic [COORD_WIDTH-1:0]   cmd_cy,
   output logic [3:0]               cmd_color,
   output logic [COORD_WIDTH:0]     cmd_x,
   output logic [COORD_WIDTH-1:0]   cmd_y
);

   localparam int DW = COORD_WIDTH + 4;

   logic [COORD_WIDTH-1:0] cx_ff, cx_in;
   logic [COORD_WIDTH-1:0] cy_ff, cy_in;
   logic [3:0]             color_ff, color_in;
   logic [COORD_WIDTH:0]   x_ff, x_in;
   logic [COORD_WIDTH-1:0] y_ff, y_in;
   logic signed [DW-1:0]   dec_ff, dec_in;
   logic                   finished_ff, finished_in;

   logic                   accept;
   logic                   take_y;
   logic                   take_x;
   logic [COORD_WIDTH-1:0] y1;
   logic signed [DW-1:0]   d1;
   logic [COORD_WIDTH:0]   x2;
   logic signed [DW-1:0]   d2;
   logic signed [DW-1:0]   neg_y;

   assign req_stall = cmd_stall;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && !cmd_stall;

   // One midpoint step: y first, then x, on the updated decision value
   always_comb begin
      neg_y  = $signed(DW'(0) - {4'b0, y_ff});
      take_y = dec_ff > neg_y;
      y1     = take_y ? y_ff - COORD_WIDTH'(1) : y_ff;
      d1     = take_y ? $signed(dec_ff + DW'(1) - {3'b0, y1, 1'b0}) : dec_ff;
      take_x = d1 <= $signed({3'b0, x_ff});
      x2     = take_x ? x_ff + (COORD_WIDTH+1)'(1) : x_ff;
      d2     = take_x ? $signed(d1 + DW'(1) + {2'b0, x2, 1'b0}) : d1;
   end

   always_comb begin
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      color_in    = color_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      dec_in      = dec_ff;
      finished_in = finished_ff;
      cmd_cx      = cx_ff;
      cmd_cy      = cy_ff;
      cmd_color   = color_ff;
      cmd_x       = x2;
      cmd_y       = y1;
      if (req_action == tbc_pkg::ACTION_START) begin
         cmd_kind  = tbc_pkg::CMD_START;
         cmd_cx    = req_center_x;
         cmd_cy    = req_center_y;
         cmd_color = req_pen_color;
         cmd_x     = '0;
         cmd_y     = req_radius;
         if (accept) begin
            cx_in       = req_center_x;
            cy_in       = req_center_y;
            color_in    = req_pen_color;
            x_in        = '0;
            y_in        = req_radius;
            dec_in      = $signed(DW'(3) - {3'b0, req_radius, 1'b0});
            finished_in = (req_radius == '0);
         end
      end else if (finished_ff) begin
         cmd_kind = tbc_pkg::CMD_DONE;
      end else if (y1 == '0) begin
         cmd_kind = tbc_pkg::CMD_DONE;
         if (accept) begin
            x_in        = x2;
            y_in        = y1;
            dec_in      = d2;
            finished_in = 1'b1;
         end
      end else begin
         cmd_kind = tbc_pkg::CMD_PIXELS;
         if (accept) begin
            x_in   = x2;
            y_in   = y1;
            dec_in = d2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff       <= '0;
         cy_ff       <= '0;
         color_ff    <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         dec_ff      <= '0;
         finished_ff <= 1'b1;
      end else begin
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
         color_ff    <= color_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         dec_ff      <= dec_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ----- hdl/tbc_queue.sv -----
module tbc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = rd_ptr_ff ? slot1_ff : slot0_ff;
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      slot0_in  = (push && !wr_ptr_ff) ? push_data : slot0_ff;
      slot1_in  = (push &&  wr_ptr_ff) ? push_data : slot1_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/tbc_back.sv -----
module tbc_back #(
   parameter int COORD_WIDTH = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_stall,
   input  tbc_pkg::cmd_kind_type         cmd_kind,
   input  logic [COORD_WIDTH-1:0]        cmd_cx,
   input  logic [COORD_WIDTH-1:0]        cmd_cy,
   input  logic [3:0]                    cmd_color,
   input  logic [COORD_WIDTH:0]          cmd_x,
   input  logic [COORD_WIDTH-1:0]        cmd_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH+1:0] rsp_pixel_x,
   output logic signed [COORD_WIDTH+1:0] rsp_pixel_y,
   output logic [3:0]                    rsp_pixel_color,
   output logic                          rsp_pixel_valid,
   output logic                          rsp_circle_done,
   output logic                          rsp_last
);

   localparam int OW = COORD_WIDTH + 2;

   logic                  busy_ff, busy_in;
   tbc_pkg::cmd_kind_type kind_ff, kind_in;
   logic [COORD_WIDTH-1:0] cx_ff, cx_in;
   logic [COORD_WIDTH-1:0] cy_ff, cy_in;
   logic [3:0]             color_ff, color_in;
   logic [COORD_WIDTH:0]   x_ff, x_in;
   logic [COORD_WIDTH-1:0] y_ff, y_in;
   logic [1:0]             mir_ff, mir_in;
   logic [2:0]             nb_ff, nb_in;

   logic                   out_valid_ff, out_valid_in;
   logic [OW-1:0]          out_x_ff, out_x_in;
   logic [OW-1:0]          out_y_ff, out_y_in;
   logic [3:0]             out_color_ff, out_color_in;
   logic                   out_pix_ff, out_pix_in;
   logic                   out_done_ff, out_done_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic                   fire;
   logic                   beat_last;
   logic                   take;
   logic [OW-1:0]          ext_x;
   logic [OW-1:0]          ext_y;
   logic [OW-1:0]          off_x;
   logic [OW-1:0]          off_y;
   logic [1:0]             dx;
   logic [1:0]             dy;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = busy_ff && out_free;
   assign cmd_stall = busy_ff && !(fire && beat_last);
   assign take      = cmd_valid && !cmd_stall;

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = $signed(out_x_ff);
   assign rsp_pixel_y     = $signed(out_y_ff);
   assign rsp_pixel_color = out_color_ff;
   assign rsp_pixel_valid = out_pix_ff;
   assign rsp_circle_done = out_done_ff;
   assign rsp_last        = out_last_ff;

   // Pixel offsets of the current beat
   always_comb begin
      ext_x     = {1'b0, x_ff};
      ext_y     = {2'b0, y_ff};
      dx        = 2'b00;
      dy        = 2'b00;
      off_x     = '0;
      off_y     = '0;
      beat_last = 1'b1;
      case (kind_ff)
         tbc_pkg::CMD_START: begin
            // Axis points: below, above, right, left of the center
            if (mir_ff[1]) begin
               off_x = mir_ff[0] ? OW'(0) - ext_y : ext_y;
            end else begin
               off_y = mir_ff[0] ? OW'(0) - ext_y : ext_y;
            end
            beat_last = (mir_ff == tbc_pkg::MIRROR_LAST);
         end
         tbc_pkg::CMD_PIXELS: begin
            off_x     = mir_ff[0] ? OW'(0) - ext_x : ext_x;
            off_y     = (mir_ff[0] ^ mir_ff[1]) ? OW'(0) - ext_y : ext_y;
            dx        = tbc_pkg::nb_dx(nb_ff);
            dy        = tbc_pkg::nb_dy(nb_ff);
            beat_last = (mir_ff == tbc_pkg::MIRROR_LAST) &&
                        (nb_ff == tbc_pkg::NEIGHBOR_LAST);
         end
         default: beat_last = 1'b1;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      mir_in   = mir_ff;
      nb_in    = nb_ff;
      if (take) begin
         busy_in  = 1'b1;
         kind_in  = cmd_kind;
         cx_in    = cmd_cx;
         cy_in    = cmd_cy;
         color_in = cmd_color;
         x_in     = cmd_x;
         y_in     = cmd_y;
         mir_in   = '0;
         nb_in    = '0;
      end else if (fire) begin
         mir_in = mir_ff + 2'd1;
         if (mir_ff == tbc_pkg::MIRROR_LAST) begin
            nb_in = nb_ff + 3'd1;
         end
         if (beat_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_pix_in   = out_pix_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_last_in  = beat_last;
         if (kind_ff == tbc_pkg::CMD_DONE) begin
            out_x_in     = '0;
            out_y_in     = '0;
            out_color_in = '0;
            out_pix_in   = 1'b0;
            out_done_in  = 1'b1;
         end else begin
            out_x_in     = {2'b0, cx_ff} + off_x + {{(OW-2){dx[1]}}, dx};
            out_y_in     = {2'b0, cy_ff} + off_y + {{(OW-2){dy[1]}}, dy};
            out_color_in = color_ff;
            out_pix_in   = 1'b1;
            out_done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      color_ff     <= color_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      mir_ff       <= mir_in;
      nb_ff        <= nb_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_pix_ff   <= out_pix_in;
      out_done_ff  <= out_done_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hdl/thick_bresenham_circle_generator.sv -----
// A request passes the command queue and the expansion unit's command and output
// registers before its first response. A start gives 4 responses, a step 28, and
// a finished step 1, one per cycle while rsp_stall is low and commands wait.
// Requests enter a two-entry command queue, so up to two wait behind the active one.
// Reset (synchronous, active high): no circle active, queue and output empty.
module thick_bresenham_circle_generator #(
   parameter int COORD_WIDTH = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [COORD_WIDTH-1:0]        req_center_x,
   input  logic [COORD_WIDTH-1:0]        req_center_y,
   input  logic [COORD_WIDTH-1:0]        req_radius,
   input  logic [3:0]                    req_pen_color,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH+1:0] rsp_pixel_x,
   output logic signed [COORD_WIDTH+1:0] rsp_pixel_y,
   output logic [3:0]                    rsp_pixel_color,
   output logic                          rsp_pixel_valid,
   output logic                          rsp_circle_done,
   output logic                          rsp_last
);

   // Command word: kind, center x, center y, color, x, y
   localparam int QW = 2 + COORD_WIDTH + COORD_WIDTH + 4 + (COORD_WIDTH + 1) + COORD_WIDTH;

   // Front side: holds the circle state and runs the midpoint recurrence
   logic                   f_valid;
   logic                   f_stall;
   tbc_pkg::cmd_kind_type  f_kind;
   logic [COORD_WIDTH-1:0] f_cx;
   logic [COORD_WIDTH-1:0] f_cy;
   logic [3:0]             f_color;
   logic [COORD_WIDTH:0]   f_x;
   logic [COORD_WIDTH-1:0] f_y;

   // Back side: expands one command into its responses
   logic                   b_valid;
   logic                   b_stall;
   logic [QW-1:0]          b_data;
   tbc_pkg::cmd_kind_type  b_kind;
   logic [COORD_WIDTH-1:0] b_cx;
   logic [COORD_WIDTH-1:0] b_cy;
   logic [3:0]             b_color;
   logic [COORD_WIDTH:0]   b_x;
   logic [COORD_WIDTH-1:0] b_y;

   tbc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_pen_color (req_pen_color),
      .cmd_valid     (f_valid),
      .cmd_stall     (f_stall),
      .cmd_kind      (f_kind),
      .cmd_cx        (f_cx),
      .cmd_cy        (f_cy),
      .cmd_color     (f_color),
      .cmd_x         (f_x),
      .cmd_y         (f_y)
   );

   // Decouple the recurrence from the pixel expansion
   tbc_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_stall (f_stall),
      .push_data  ({f_kind, f_cx, f_cy, f_color, f_x, f_y}),
      .pop_valid  (b_valid),
      .pop_stall  (b_stall),
      .pop_data   (b_data)
   );

   assign {b_kind, b_cx, b_cy, b_color, b_x, b_y} = b_data;

   tbc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (b_valid),
      .cmd_stall       (b_stall),
      .cmd_kind        (b_kind),
      .cmd_cx          (b_cx),
      .cmd_cy          (b_cy),
      .cmd_color       (b_color),
      .cmd_x           (b_x),
      .cmd_y           (b_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_circle_done (rsp_circle_done),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- test/tb_thick_bresenham_circle_generator.sv -----
module tb_thick_bresenham_circle_generator;

   localparam int CW            = 10;
   localparam int OW            = CW + 2;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 85;

   // One expected or observed pixel on the result channel
   typedef struct {
      logic signed [OW-1:0] x;
      logic signed [OW-1:0] y;
      logic [3:0]           color;
      logic                 on;
      logic                 done;
      logic                 last;
   } circle_pixel_type;

   // Tracks the circle state and holds the pixels that the block still owes
   class circle_scoreboard_type;
      int  center_x, center_y, color;
      int  arc_x, arc_y, decision;
      bit  finished;
      circle_pixel_type owed_pixels[$];
      int  failures, reports;
      int  starts, steps, pixels_seen, dones_seen;

      function new();
         center_x = 0;
         center_y = 0;
         color    = 0;
         arc_x    = 0;
         arc_y    = 0;
         decision = 0;
         finished = 1'b1;
         failures = 0;
         reports  = 0;
         starts   = 0;
         steps    = 0;
         pixels_seen = 0;
         dones_seen  = 0;
      endfunction

      function void owe_pixel(int px, int py, int col, bit on, bit done, bit last);
         circle_pixel_type p;
         p.x     = px[OW-1:0];
         p.y     = py[OW-1:0];
         p.color = col[3:0];
         p.on    = on;
         p.done  = done;
         p.last  = last;
         owed_pixels.push_back(p);
      endfunction

      // Advance the circle for one accepted request and queue its pixels
      function void note_request(logic act, logic [CW-1:0] cx, logic [CW-1:0] cy,
                                 logic [CW-1:0] r, logic [3:0] col);
         int ofs_x[7] = '{0, 1, 0, 1, -1, 0, -1};
         int ofs_y[7] = '{0, 0, 1, 1, 0, -1, -1};
         int mir_x[4] = '{1, -1, 1, -1};
         int mir_y[4] = '{1, -1, -1, 1};
         int rad;
         if (act == tbc_pkg::ACTION_START) begin
            starts++;
            center_x = int'(cx);
            center_y = int'(cy);
            color    = int'(col);
            rad      = int'(r);
            arc_x    = 0;
            arc_y    = rad;
            decision = 3 - 2 * rad;
            finished = (rad == 0);
            owe_pixel(center_x, center_y + rad, color, 1'b1, 1'b0, 1'b0);
            owe_pixel(center_x, center_y - rad, color, 1'b1, 1'b0, 1'b0);
            owe_pixel(center_x + rad, center_y, color, 1'b1, 1'b0, 1'b0);
            owe_pixel(center_x - rad, center_y, color, 1'b1, 1'b0, 1'b1);
            return;
         end
         steps++;
         if (finished) begin
            owe_pixel(0, 0, 0, 1'b0, 1'b1, 1'b1);
            return;
         end
         if (decision > -arc_y) begin
            arc_y--;
            decision += 1 - 2 * arc_y;
         end
         if (decision <= arc_x) begin
            arc_x++;
            decision += 1 + 2 * arc_x;
         end
         if (arc_y == 0) begin
            finished = 1'b1;
            owe_pixel(0, 0, 0, 1'b0, 1'b1, 1'b1);
            return;
         end
         for (int n = 0; n < 7; n++)
            for (int m = 0; m < 4; m++)
               owe_pixel(center_x + mir_x[m] * arc_x + ofs_x[n],
                         center_y + mir_y[m] * arc_y + ofs_y[n],
                         color, 1'b1, 1'b0, (n == 6 && m == 3));
      endfunction

      function bit circle_active();
         return !finished;
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction

      // Compare one accepted response with the oldest owed pixel
      function void check_response(logic signed [OW-1:0] px, logic signed [OW-1:0] py,
                                   logic [3:0] col, logic on, logic done, logic last);
         circle_pixel_type want;
         if (done === 1'b1) dones_seen++;
         else pixels_seen++;
         if (owed_pixels.size() == 0) begin
            failures++;
            if (reports < REPORT_LIMIT) begin
               reports++;
               $display("unexpected response: x=%0d y=%0d color=%0d on=%b done=%b last=%b",
                        px, py, col, on, done, last);
            end
            return;
         end
         want = owed_pixels.pop_front();
         if (px !== want.x || py !== want.y || col !== want.color ||
             on !== want.on || done !== want.done || last !== want.last) begin
            failures++;
            if (reports < REPORT_LIMIT) begin
               reports++;
               $display("mismatch: expected x=%0d y=%0d color=%0d on=%b done=%b last=%b",
                        want.x, want.y, want.color, want.on, want.done, want.last);
               $display("          actual   x=%0d y=%0d color=%0d on=%b done=%b last=%b",
                        px, py, col, on, done, last);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_action;
   logic [CW-1:0]        req_center_x;
   logic [CW-1:0]        req_center_y;
   logic [CW-1:0]        req_radius;
   logic [3:0]           req_pen_color;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [OW-1:0] rsp_pixel_x;
   logic signed [OW-1:0] rsp_pixel_y;
   logic [3:0]           rsp_pixel_color;
   logic                 rsp_pixel_valid;
   logic                 rsp_circle_done;
   logic                 rsp_last;

   // Percent of cycles in which the sender idles and the receiver stalls
   int send_idle_pct = 0;
   int stall_pct     = 0;

   circle_scoreboard_type sb;

   thick_bresenham_circle_generator #(
      .COORD_WIDTH(CW)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .req_pen_color  (req_pen_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_pixel_valid(rsp_pixel_valid),
      .rsp_circle_done(rsp_circle_done),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: check each accepted response against the values sampled at the
   // edge, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                           rsp_pixel_valid, rsp_circle_done, rsp_last);
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Present one request, hold it until the block takes it, then note it.
   // Idle cycles come first so that valid is never dropped and raised in one step.
   task automatic send_request(input logic act, input logic [CW-1:0] cx,
                               input logic [CW-1:0] cy, input logic [CW-1:0] r,
                               input logic [3:0] col);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_radius    <= r;
      req_pen_color <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(act, cx, cy, r, col);
   endtask

   // A step ignores its payload, so fill it with noise
   task automatic send_step();
      send_request(tbc_pkg::ACTION_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                   4'($urandom));
   endtask

   // Drop valid and hold until the block has delivered every owed pixel
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly whole circles: a start followed by steps until done, sometimes a few
   // steps past the end, sometimes abandoned early by the next start. A small share
   // of requests is pure noise with a random action.
   task automatic run_random_circles(input int budget);
      int sent;
      int cap;
      int radius_pick;
      int n;
      bit abandon;
      logic [CW-1:0] r;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 8) begin
            send_request(1'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                         4'($urandom));
            sent++;
         end else begin
            radius_pick = $urandom_range(9);
            if (radius_pick < 7)      r = CW'($urandom_range(0, 8));
            else if (radius_pick < 9) r = CW'($urandom_range(9, 24));
            else                      r = CW'($urandom);
            abandon = ($urandom_range(99) < 25);
            send_request(tbc_pkg::ACTION_START, CW'($urandom), CW'($urandom), r,
                         4'($urandom));
            sent++;
            // Cap long circles so large radii only run their opening steps
            cap = abandon ? $urandom_range(0, 6) : 40;
            n = 0;
            while (n < cap && sb.circle_active() && sent < budget) begin
               send_step();
               n++;
               sent++;
            end
            if (!abandon) begin
               repeat ($urandom_range(0, 2)) begin
                  send_step();
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      int idle_pcts[4];
      int stall_pcts[4];
      idle_pcts  = '{0, 79, 0, 10};
      stall_pcts = '{0, 0, 79, 10};
      sb = new();
      req_valid     <= 1'b0;
      req_action    <= tbc_pkg::ACTION_START;
      req_center_x  <= '0;
      req_center_y  <= '0;
      req_radius    <= '0;
      req_pen_color <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: step with no circle active right after reset
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      // Zero radius: four center pixels, then done, then done again
      send_request(tbc_pkg::ACTION_START, '0, '0, '0, 4'd0);
      send_request(tbc_pkg::ACTION_STEP, '1, '1, '1, 4'hf);
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      // Largest radius at the far corner: pixel rows reach the top of the range
      send_request(tbc_pkg::ACTION_START, '1, '1, '1, 4'hf);
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      send_request(tbc_pkg::ACTION_STEP, '1, '1, '1, 4'hf);
      // Start while a circle is active; coordinates go negative
      send_request(tbc_pkg::ACTION_START, '0, '0, '1, 4'd9);
      send_request(tbc_pkg::ACTION_STEP, '1, '1, '1, 4'hf);
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      // Radius one: the first step already finishes the circle
      send_request(tbc_pkg::ACTION_START, CW'(512), CW'(511), CW'(1), 4'd5);
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      send_request(tbc_pkg::ACTION_STEP, '0, '0, '0, 4'd0);
      // A small circle at a mixed corner, run to completion
      send_request(tbc_pkg::ACTION_START, '1, '0, CW'(3), 4'd10);
      while (sb.circle_active()) send_step();
      send_step();
      wait_drained();

      // Random part, one phase per idle pattern, drained between phases
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_pcts[phase];
         stall_pct     = stall_pcts[phase];
         run_random_circles(PHASE_ITEMS);
         wait_drained();
      end
      send_idle_pct = 0;
      stall_pct     = 0;

      // Let any stray response surface before judging the run
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d circle starts and %0d steps under four idle/stall patterns",
               sb.starts, sb.steps);
      $display("checked %0d pixels and %0d done markers, %0d mismatches",
               sb.pixels_seen, sb.dones_seen, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
